/* hw/rtl/sdtq_pkg.sv */
// package for the sorted deadline timer queue: payload types, codes, sizes
package sdtq_pkg;

    localparam int unsigned SLOTS_DEF = 16;
    localparam int unsigned TIME_W    = 63;
    localparam int unsigned HANDLE_W  = 4;
    localparam int unsigned HANDLES   = 16;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_PAST      = 3'd1,
        ST_FULL      = 3'd2,
        ST_BUSY      = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_USED  = 3'd5,
        ST_FIRED     = 3'd6,
        ST_TICK_END  = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0]          kind;
        logic [HANDLE_W-1:0] handle;
        logic                clock_sel;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   now_monotonic;
        logic [TIME_W-1:0]   now_realtime;
    } t_in_item;

    typedef struct packed {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] out_handle;
        logic                out_clock;
        logic [TIME_W-1:0]   remaining;
        logic                last;
        logic [TIME_W-1:0]   next_due_monotonic;
        logic                monotonic_valid;
        logic [TIME_W-1:0]   next_due_realtime;
        logic                realtime_valid;
    } t_out_item;

    // operation broadcast to every cell of a queue
    typedef enum logic [2:0] {
        COP_HOLD   = 3'b001,
        COP_INSERT = 3'b010,
        COP_REMOVE = 3'b100
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } t_cell_ctl;

    // what each cell reports back
    typedef struct packed {
        logic                valid;
        logic                later;
        logic                match;
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } t_cell_stat;

endpackage

/* hw/rtl/sorted_deadline_timer_queue.sv */
// sorted deadline timer queue: an accepted add or cancel gives one result
// each result passes through a decide step, a cell-chain shift step and an output step
// the next item is taken the cycle after a result is registered
// a tick gives one fired result per expired timer, moves from monotonic to realtime, then an end
// marker; a held output result stalls the block for as long as it is held
// reset (synchronous, active low) empties both queues and frees every handle
module sorted_deadline_timer_queue
#(
    parameter int unsigned TIMER_SLOTS = sdtq_pkg::SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sdtq_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sdtq_pkg::t_out_item  o_item
);
    import sdtq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_in_item            r_in;
    logic                r_q;       // tick: queue being drained
    logic [HANDLES-1:0]  r_busy, n_busy;
    t_cell_ctl           w_ctl [2];
    logic                w_full [2];
    logic                w_found [2];
    logic [TIME_W-1:0]   w_fdl [2];
    logic                w_hv [2];
    logic [TIME_W-1:0]   w_hd [2];
    logic [HANDLE_W-1:0] w_hh [2];

    // pending result, finished after the shift settles
    logic                r_pend_v;
    logic [2:0]          r_p_status;
    logic [HANDLE_W-1:0] r_p_handle;
    logic                r_p_clock;
    logic [TIME_W-1:0]   r_p_rem;
    logic                r_p_last;
    logic                r_ovalid;
    t_out_item           r_out;

    for (genvar q = 0; q < 2; q++) begin : g_q
        sdtq_chain #(.SLOTS(TIMER_SLOTS)) u_chain (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl[q]),
            .o_full          (w_full[q]),
            .o_found         (w_found[q]),
            .o_found_deadline(w_fdl[q]),
            .o_head_valid    (w_hv[q]),
            .o_head_deadline (w_hd[q]),
            .o_head_handle   (w_hh[q])
        );
    end

    logic [TIME_W-1:0] w_now [2];
    assign w_now[0] = r_in.now_monotonic;
    assign w_now[1] = r_in.now_realtime;

    logic w_out_free;
    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && !r_pend_v;

    // decision in exec state
    logic                w_emit;
    logic [2:0]          w_status;
    logic [HANDLE_W-1:0] w_handle;
    logic                w_clock;
    logic [TIME_W-1:0]   w_rem;
    logic                w_last;
    logic                w_next_q;
    logic                w_cq;

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        w_ctl[0]    = '{op: COP_HOLD, deadline: r_in.deadline, handle: r_in.handle};
        w_ctl[1]    = '{op: COP_HOLD, deadline: r_in.deadline, handle: r_in.handle};
        w_emit      = 1'b0;
        w_status    = ST_ADDED;
        w_handle    = r_in.handle;
        w_clock     = r_in.clock_sel;
        w_rem       = '0;
        w_last      = 1'b1;
        w_next_q    = r_q;
        w_cq        = w_found[1] && !w_found[0];
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_SHIFT;
                case (r_in.kind)
                    KIND_ADD: begin
                        w_emit = 1'b1;
                        if (r_in.deadline <= w_now[r_in.clock_sel]) begin
                            w_status = ST_PAST;
                        end else if (w_full[r_in.clock_sel]) begin
                            w_status = ST_FULL;
                        end else if (r_busy[r_in.handle]) begin
                            w_status = ST_BUSY;
                        end else begin
                            w_ctl[r_in.clock_sel].op = COP_INSERT;
                            n_busy[r_in.handle]      = 1'b1;
                        end
                    end
                    KIND_CANCEL: begin
                        w_emit = 1'b1;
                        if (r_busy[r_in.handle] && (w_found[0] || w_found[1])) begin
                            w_status   = ST_CANCELLED;
                            w_clock    = w_cq;
                            w_ctl[w_cq].op = COP_REMOVE;
                            n_busy[r_in.handle] = 1'b0;
                            if (w_fdl[w_cq] > w_now[w_cq]) begin
                                w_rem = w_fdl[w_cq] - w_now[w_cq];
                            end
                        end else begin
                            w_status = ST_NOT_USED;
                            w_clock  = 1'b0;
                        end
                    end
                    KIND_TICK: begin
                        w_emit = 1'b1;
                        if (w_hv[r_q] && (w_now[r_q] > w_hd[r_q])) begin
                            w_status  = ST_FIRED;
                            w_handle  = w_hh[r_q];
                            w_clock   = r_q;
                            w_last    = 1'b0;
                            w_ctl[r_q].op = COP_REMOVE;
                            w_ctl[r_q].handle = w_hh[r_q];
                            n_busy[w_hh[r_q]] = 1'b0;
                        end else if (!r_q) begin
                            // monotonic drained, go on to realtime
                            w_emit   = 1'b0;
                            w_next_q = 1'b1;
                            n_state  = S_EXEC;
                        end else begin
                            w_status = ST_TICK_END;
                            w_handle = '0;
                            w_clock  = 1'b0;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SHIFT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = r_p_last ? S_IDLE : S_EXEC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
            r_q      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            if (r_state == S_IDLE) r_q <= 1'b0;
            else if (r_state == S_EXEC) r_q <= w_next_q;
            if (r_state == S_EXEC && w_emit) r_pend_v <= 1'b1;
            else if (r_state == S_EMIT && w_out_free) r_pend_v <= 1'b0;
            if (r_state == S_EMIT && w_out_free) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && o_ready) r_in <= i_item;
        if (r_state == S_EXEC && w_emit) begin
            r_p_status <= w_status;
            r_p_handle <= w_handle;
            r_p_clock  <= w_clock;
            r_p_rem    <= w_rem;
            r_p_last   <= w_last;
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out.status             <= r_p_status;
            r_out.out_handle         <= r_p_handle;
            r_out.out_clock          <= r_p_clock;
            r_out.remaining          <= r_p_rem;
            r_out.last               <= r_p_last;
            r_out.next_due_monotonic <= w_hv[0] ? w_hd[0] : '0;
            r_out.monotonic_valid    <= w_hv[0];
            r_out.next_due_realtime  <= w_hv[1] ? w_hd[1] : '0;
            r_out.realtime_valid     <= w_hv[1];
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

`ifndef SYNTH
    // a result is only moved out while one is pending
    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_pend_v)
        else $error("emit without pending result");
    // no item accepted while a result is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> !o_ready)
        else $error("accept while busy");
    // a fired head frees its handle
    a_fire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_status == ST_FIRED && w_emit) |=> !r_busy[$past(w_hh[r_q])])
        else $error("fired handle still busy");
`endif
endmodule

/* hw/rtl/sdtq_cell.sv */
// one queue slot: holds a deadline and handle, shifts with its neighbors
module sdtq_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sdtq_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_prev_later,
    input  logic                     i_prev_kill,
    input  logic                     i_prev_valid,
    input  logic [sdtq_pkg::TIME_W-1:0]   i_prev_deadline,
    input  logic [sdtq_pkg::HANDLE_W-1:0] i_prev_handle,
    input  logic                     i_next_valid,
    input  logic [sdtq_pkg::TIME_W-1:0]   i_next_deadline,
    input  logic [sdtq_pkg::HANDLE_W-1:0] i_next_handle,
    output logic                     o_kill,
    output sdtq_pkg::t_cell_stat     o_stat
);
    import sdtq_pkg::*;

    logic                r_valid;
    logic [TIME_W-1:0]   r_deadline;
    logic [HANDLE_W-1:0] r_handle;
    logic                n_valid;
    logic [TIME_W-1:0]   n_deadline;
    logic [HANDLE_W-1:0] n_handle;
    logic                w_later;
    logic                w_match;

    // compare against the broadcast item
    assign w_later = r_valid && (r_deadline > i_ctl.deadline);
    assign w_match = r_valid && (r_handle == i_ctl.handle);
    // removal point: this cell or any earlier one matched
    assign o_kill  = i_prev_kill || w_match;

    // shift decision
    always_comb begin
        n_valid    = r_valid;
        n_deadline = r_deadline;
        n_handle   = r_handle;
        case (i_ctl.op)
            COP_INSERT: begin
                if (i_prev_later) begin
                    n_valid    = i_prev_valid;
                    n_deadline = i_prev_deadline;
                    n_handle   = i_prev_handle;
                end else if (!r_valid || w_later) begin
                    n_valid    = 1'b1;
                    n_deadline = i_ctl.deadline;
                    n_handle   = i_ctl.handle;
                end
            end
            COP_REMOVE: begin
                if (o_kill) begin
                    n_valid    = i_next_valid;
                    n_deadline = i_next_deadline;
                    n_handle   = i_next_handle;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_deadline <= n_deadline;
        r_handle   <= n_handle;
    end

    assign o_stat.valid    = r_valid;
    assign o_stat.later    = w_later || !r_valid;
    assign o_stat.match    = w_match;
    assign o_stat.deadline = r_deadline;
    assign o_stat.handle   = r_handle;
endmodule

/* hw/rtl/sdtq_chain.sv */
// one sorted queue built as a chain of cells
module sdtq_chain #(
    parameter int unsigned SLOTS = sdtq_pkg::SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdtq_pkg::t_cell_ctl  i_ctl,
    output logic                 o_full,
    output logic                 o_found,
    output logic [sdtq_pkg::TIME_W-1:0]   o_found_deadline,
    output logic                 o_head_valid,
    output logic [sdtq_pkg::TIME_W-1:0]   o_head_deadline,
    output logic [sdtq_pkg::HANDLE_W-1:0] o_head_handle
);
    import sdtq_pkg::*;

    t_cell_stat w_stat [SLOTS];
    logic       w_kill [SLOTS];
    logic [SLOTS-1:0] w_match;

    // a cell moves its predecessor in once the insert point lies before it
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        logic                pl;
        logic                pk;
        logic                pv;
        logic [TIME_W-1:0]   pd;
        logic [HANDLE_W-1:0] ph;
        logic                nv;
        logic [TIME_W-1:0]   nd;
        logic [HANDLE_W-1:0] nh;
        if (g == 0) begin : g_first
            assign pl = 1'b0;
            assign pk = 1'b0;
            assign pv = 1'b0;
            assign pd = '0;
            assign ph = '0;
        end else begin : g_mid
            assign pl = w_stat[g-1].later;
            assign pk = w_kill[g-1];
            assign pv = w_stat[g-1].valid;
            assign pd = w_stat[g-1].deadline;
            assign ph = w_stat[g-1].handle;
        end
        if (g == SLOTS-1) begin : g_last
            assign nv = 1'b0;
            assign nd = '0;
            assign nh = '0;
        end else begin : g_inner
            assign nv = w_stat[g+1].valid;
            assign nd = w_stat[g+1].deadline;
            assign nh = w_stat[g+1].handle;
        end
        sdtq_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (i_ctl),
            .i_prev_later   (pl),
            .i_prev_kill    (pk),
            .i_prev_valid   (pv),
            .i_prev_deadline(pd),
            .i_prev_handle  (ph),
            .i_next_valid   (nv),
            .i_next_deadline(nd),
            .i_next_handle  (nh),
            .o_kill         (w_kill[g]),
            .o_stat         (w_stat[g])
        );
        assign w_match[g] = w_stat[g].match;
    end

    // found deadline: handles are unique so an or-reduction selects it
    always_comb begin
        o_found_deadline = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_match[i]) o_found_deadline = o_found_deadline | w_stat[i].deadline;
        end
    end

    assign o_found         = |w_match;
    assign o_full          = w_stat[SLOTS-1].valid;
    assign o_head_valid    = w_stat[0].valid;
    assign o_head_deadline = w_stat[0].deadline;
    assign o_head_handle   = w_stat[0].handle;
endmodule
